@@ hdl/rect_around_segment_top_defines.svh @@
// Assertion macros used by the rect_around_segment_top RTL
`ifndef RECT_AROUND_SEGMENT_TOP_DEFINES_SVH
`define RECT_AROUND_SEGMENT_TOP_DEFINES_SVH
// implication checked on every rising edge outside reset
`define RAS_ASSERT_IMP(label, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define RAS_ASSERT_NXT(label, pre, post, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

@@ hdl/ras_pkg.sv @@
// ============================================================================
// ras_pkg
// Shared types and constants for the rectangle-around-segment block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package ras_pkg;
    localparam int WIDE_BITS = 64;
    localparam int GUARD = 24;
    localparam logic [31:0] KINV = 32'h26DD3B6A;
    localparam int NORM_POS = 59;

    // offset selection code
    localparam logic [1:0] CASE_VERT  = 2'd0;
    localparam logic [1:0] CASE_HORIZ = 2'd1;
    localparam logic [1:0] CASE_GEN   = 2'd2;

    typedef logic signed [WIDE_BITS-1:0] wide_t;
endpackage
`default_nettype wire

@@ hdl/ras_stream_if.sv @@
// ============================================================================
// ras_stream_if
// Valid/ready channel carrying a generic payload.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
interface ras_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ras_cordic_stage.sv @@
// ============================================================================
// ras_cordic_stage
// One registered CORDIC vectoring micro-rotation with fixed shift.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module ras_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire ras_pkg::wide_t a_in,
    input  wire ras_pkg::wide_t b_in,
    input  wire ras_pkg::wide_t u_in,
    input  wire ras_pkg::wide_t v_in,
    output ras_pkg::wide_t      a_reg,
    output ras_pkg::wide_t      b_reg,
    output ras_pkg::wide_t      u_reg,
    output ras_pkg::wide_t      v_reg
);
    ras_pkg::wide_t sa, sb, su, sv;
    ras_pkg::wide_t a_next, b_next, u_next, v_next;

    always_comb
    begin
        sa = a_in >>> SHIFT;
        sb = b_in >>> SHIFT;
        su = u_in >>> SHIFT;
        sv = v_in >>> SHIFT;
        if (!b_in[ras_pkg::WIDE_BITS-1])
        begin
            a_next = a_in + sb;
            b_next = b_in - sa;
            u_next = u_in - sv;
            v_next = v_in + su;
        end
        else
        begin
            a_next = a_in - sb;
            b_next = b_in + sa;
            u_next = u_in + sv;
            v_next = v_in - su;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end
endmodule
`default_nettype wire

@@ hdl/rect_around_segment_top.sv @@
// ============================================================================
// rect_around_segment_top
// Four corners of a rectangle centered on a segment, by pipelined CORDIC.
// ============================================================================
// Usage:
//  - in_seg (sink) carries one segment per transaction: first_x, first_y,
//    second_x, second_y (signed Q16.16) and rect_width (unsigned Q15.16).
//  - out_rect (source) carries corner_a..corner_d x/y and clipped.
//  - One transaction accepted per cycle while not stalled; every segment
//    gives exactly one result transaction.
//  - Depth: CORDIC_STEPS + 4 register stages (prep, normalize,
//    CORDIC_STEPS micro-rotations, round, corner/saturate); out_rect.valid
//    is the valid bit of the last stage.
//    The depth is set by the CORDIC chain, one micro-rotation per stage.
//  - The whole pipe advances together; when out_rect.ready is low and the
//    output holds a result, the pipe freezes and in_seg.ready drops.
//    Bubbles are not collapsed: the stall is global, so empty stages wait
//    too. Nothing is dropped or repeated.
//  - Reset (rst_n low, asynchronous) clears all valid bits; payload
//    registers are not reset.
//  - Vertical segments (dx = 0) and horizontal ones (dy = 0) bypass the
//    CORDIC result and use half the width directly.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "rect_around_segment_top_defines.svh"
module rect_around_segment_top #(
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ras_stream_if.sink   in_seg,
    ras_stream_if.source out_rect
);
    localparam int NST = CORDIC_STEPS + 4;
    typedef ras_pkg::wide_t wide_t;

    // payload carried alongside the datapath
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic [30:0]        h;
        logic [1:0]         sel;
    } side_t;

    logic [NST-1:0] vld_reg;
    logic           adv;
    assign adv = !vld_reg[NST-1] || out_rect.ready;
    assign in_seg.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_seg.valid};
    end

    side_t side_reg [NST-1];
    logic signed [31:0] ix1, iy1, ix2, iy2;
    logic [30:0]        iw;
    assign {ix1, iy1, ix2, iy2, iw} = in_seg.data;

    // stage 0: differences, case select, scaled width
    wide_t a0_reg, b0_reg, u0_reg;
    wide_t dx, dy;
    logic [62:0] wk;
    always_comb
    begin
        dx = wide_t'(ix2) - wide_t'(ix1);
        dy = wide_t'(iy2) - wide_t'(iy1);
        wk = {32'd0, iw} * {31'd0, ras_pkg::KINV};
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].x1 <= ix1;
            side_reg[0].y1 <= iy1;
            side_reg[0].x2 <= ix2;
            side_reg[0].y2 <= iy2;
            side_reg[0].h  <= 31'((32'(iw) + 32'd1) >> 1);
            side_reg[0].sel <= (dx == 0) ? ras_pkg::CASE_VERT :
                               (dy == 0) ? ras_pkg::CASE_HORIZ : ras_pkg::CASE_GEN;
            a0_reg <= dy[63] ? -dy : dy;
            b0_reg <= dy[63] ? dx : -dx;
            u0_reg <= wide_t'((64'(wk) + (64'd1 << (30 - ras_pkg::GUARD)))
                      >> (31 - ras_pkg::GUARD));
        end
    end

    // stage 1: normalize so max(|a|,|b|) has its top bit at NORM_POS
    wide_t a1_reg, b1_reg, u1_reg;
    wide_t mb, mx;
    logic [5:0] sh;
    always_comb
    begin
        mb = b0_reg[63] ? -b0_reg : b0_reg;
        mx = (a0_reg > mb) ? a0_reg : mb;
        sh = 6'd0;
        for (int k = 0; k <= ras_pkg::NORM_POS; k++)
        begin
            if (mx[k])
                sh = 6'(ras_pkg::NORM_POS - k);
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= side_reg[0];
            a1_reg <= a0_reg <<< sh;
            b1_reg <= b0_reg <<< sh;
            u1_reg <= u0_reg;
        end
    end

    // CORDIC chain
    wide_t ca [CORDIC_STEPS+1];
    wide_t cb [CORDIC_STEPS+1];
    wide_t cu [CORDIC_STEPS+1];
    wide_t cv [CORDIC_STEPS+1];
    assign ca[0] = a1_reg;
    assign cb[0] = b1_reg;
    assign cu[0] = u1_reg;
    assign cv[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cordic
            ras_cordic_stage #(.SHIFT(g)) u_stage (
                .clk  (clk),
                .en   (adv),
                .a_in (ca[g]),
                .b_in (cb[g]),
                .u_in (cu[g]),
                .v_in (cv[g]),
                .a_reg(ca[g+1]),
                .b_reg(cb[g+1]),
                .u_reg(cu[g+1]),
                .v_reg(cv[g+1])
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[g+2] <= side_reg[g+1];
            end
        end
    endgenerate

    // round stage: pick offset
    wide_t ox_reg, oy_reg;
    wide_t ru, rv;
    side_t sr;
    assign sr = side_reg[CORDIC_STEPS+1];
    always_comb
    begin
        ru = (cu[CORDIC_STEPS] + (wide_t'(1) <<< (ras_pkg::GUARD - 1))) >>> ras_pkg::GUARD;
        rv = (cv[CORDIC_STEPS] + (wide_t'(1) <<< (ras_pkg::GUARD - 1))) >>> ras_pkg::GUARD;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[CORDIC_STEPS+2] <= sr;
            unique case (sr.sel)
                ras_pkg::CASE_VERT:
                begin
                    ox_reg <= wide_t'({1'b0, sr.h});
                    oy_reg <= '0;
                end
                ras_pkg::CASE_HORIZ:
                begin
                    ox_reg <= '0;
                    oy_reg <= -wide_t'({1'b0, sr.h});
                end
                default:
                begin
                    ox_reg <= ru;
                    oy_reg <= rv;
                end
            endcase
        end
    end

    // corner stage with saturation
    side_t sc;
    assign sc = side_reg[CORDIC_STEPS+2];
    wide_t cr [8];
    logic signed [31:0] sat_v [8];
    logic [7:0] clp;
    always_comb
    begin
        cr[0] = wide_t'(sc.x1) - ox_reg;
        cr[1] = wide_t'(sc.y1) - oy_reg;
        cr[2] = wide_t'(sc.x1) + ox_reg;
        cr[3] = wide_t'(sc.y1) + oy_reg;
        cr[4] = wide_t'(sc.x2) + ox_reg;
        cr[5] = wide_t'(sc.y2) + oy_reg;
        cr[6] = wide_t'(sc.x2) - ox_reg;
        cr[7] = wide_t'(sc.y2) - oy_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (cr[k] > wide_t'(32'sh7FFFFFFF))
            begin
                sat_v[k] = 32'sh7FFFFFFF;
                clp[k] = 1'b1;
            end
            else if (cr[k] < -wide_t'(64'sh80000000))
            begin
                sat_v[k] = 32'sh80000000;
                clp[k] = 1'b1;
            end
            else
            begin
                sat_v[k] = cr[k][31:0];
                clp[k] = 1'b0;
            end
        end
    end

    logic [256:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {sat_v[0], sat_v[1], sat_v[2], sat_v[3],
                        sat_v[4], sat_v[5], sat_v[6], sat_v[7], |clp};
    end

    assign out_rect.valid = vld_reg[NST-1];
    assign out_rect.data  = out_reg;

    `RAS_ASSERT_IMP(a_stall_ready, out_rect.valid && !out_rect.ready, !in_seg.ready, "accept while output stalled")
    `RAS_ASSERT_NXT(a_hold_valid, out_rect.valid && !out_rect.ready, out_rect.valid, "result dropped under stall")
    `RAS_ASSERT_NXT(a_pipe_move, in_seg.valid && in_seg.ready, vld_reg[0], "accepted item lost at entry")
endmodule
`default_nettype wire
